### rtl/rational_add_div_reduce_macros.svh
// Assertion helpers for the file that carries concurrent checks.
`ifndef RATIONAL_ADD_DIV_REDUCE_MACROS_SVH
`define RATIONAL_ADD_DIV_REDUCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rad_pkg.sv
`timescale 1ns / 1ps

package rad_pkg;

  // Default width of the input integers.
  localparam int unsigned WIDTH_DEF = 16;

  // Fixed widths of the result fields.
  localparam int unsigned NUM_W = 33;
  localparam int unsigned DEN_W = 31;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation codes.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DIV    = 2'd1;
  localparam logic [1:0] OP_REDUCE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } rad_status_e;

  // Classification of one item: its status and the signs of the three products.
  typedef struct packed {
    rad_status_e status;
    logic        s0;
    logic        s1;
    logic        sd;
  } rad_cls_t;

endpackage

### rtl/rad_queue.sv
`timescale 1ns / 1ps

module rad_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = rad_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/rad_front.sv
`timescale 1ns / 1ps

module rad_front #(
  parameter int unsigned WIDTH = rad_pkg::WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [WIDTH-1:0]       a_num_i,
  input  logic signed [WIDTH-1:0]       a_den_i,
  input  logic signed [WIDTH-1:0]       b_num_i,
  input  logic signed [WIDTH-1:0]       b_den_i,
  output logic                          q_push_o,
  input  logic                          q_full_i,
  output rad_pkg::rad_cls_t             q_cls_o,
  output logic [6*(WIDTH+1)-1:0]        q_mag_o
);

  localparam int unsigned MAGW = WIDTH + 1;

  function automatic logic [MAGW-1:0] mag_of(input logic signed [WIDTH-1:0] v);
    logic signed [MAGW-1:0] ext;
    logic signed [MAGW-1:0] neg;
    ext = MAGW'(v);
    neg = -ext;
    return v[WIDTH-1] ? $unsigned(neg) : $unsigned(ext);
  endfunction

  logic                valid_q, valid_d;
  logic                accept;
  rad_pkg::rad_cls_t   cls_d, cls_q;
  logic [6*MAGW-1:0]   mag_d, mag_q;
  logic [MAGW-1:0]     an, ad, bn, bd, one;
  logic                an_s, ad_s, bn_s, bd_s;
  logic                ad_z, bn_z, bd_z;

  assign full_o   = valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q;
  assign q_cls_o  = cls_q;
  assign q_mag_o  = mag_q;

  assign an   = mag_of(a_num_i);
  assign ad   = mag_of(a_den_i);
  assign bn   = mag_of(b_num_i);
  assign bd   = mag_of(b_den_i);
  assign an_s = a_num_i[WIDTH-1];
  assign ad_s = a_den_i[WIDTH-1];
  assign bn_s = b_num_i[WIDTH-1];
  assign bd_s = b_den_i[WIDTH-1];
  assign ad_z = (a_den_i == '0);
  assign bn_z = (b_num_i == '0);
  assign bd_z = (b_den_i == '0);
  assign one  = MAGW'(1);

  // The numerator is term 0 plus term 1, the denominator is term d; each is
  // a product of two magnitudes with the sign carried alongside.
  always_comb begin
    cls_d.status = rad_pkg::ST_OK;
    cls_d.s0     = an_s;
    cls_d.s1     = 1'b0;
    cls_d.sd     = ad_s;
    mag_d        = {an, one, {MAGW{1'b0}}, {MAGW{1'b0}}, ad, one};
    unique case (opcode_i)
      rad_pkg::OP_ADD: begin
        cls_d.s0 = an_s ^ bd_s;
        cls_d.s1 = bn_s ^ ad_s;
        cls_d.sd = ad_s ^ bd_s;
        mag_d    = {an, bd, bn, ad, ad, bd};
        if (ad_z || bd_z) begin
          cls_d.status = rad_pkg::ST_ZERO_DEN;
        end
      end
      rad_pkg::OP_DIV: begin
        cls_d.s0 = an_s ^ bd_s;
        cls_d.sd = ad_s ^ bn_s;
        mag_d    = {an, bd, {MAGW{1'b0}}, {MAGW{1'b0}}, ad, bn};
        if (ad_z || bd_z) begin
          cls_d.status = rad_pkg::ST_ZERO_DEN;
        end else if (bn_z) begin
          cls_d.status = rad_pkg::ST_DIV_ZERO;
        end
      end
      default: begin
        // Reduce, and the unused code that behaves like it.
        if (ad_z) begin
          cls_d.status = rad_pkg::ST_ZERO_DEN;
        end
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !q_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
      mag_q <= mag_d;
    end
  end

endmodule

### rtl/rad_gcd.sv
`timescale 1ns / 1ps

module rad_gcd #(
  parameter int unsigned MW = 34
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] a_i,
  input  logic [MW-1:0] b_i,
  output logic          done_o,
  output logic [MW-1:0] g_o
);

  // Binary GCD: one halving or one subtract-and-halve per cycle. Both operands
  // are nonzero, so the common power of two stays below MW.
  localparam int unsigned KW = $clog2(MW);

  logic          busy_q;
  logic          done_q;
  logic [MW-1:0] a_q, b_q, g_q;
  logic [KW-1:0] k_q;
  logic [MW-1:0] a_minus_b, b_minus_a;
  logic          a_gt_b;

  assign a_minus_b = a_q - b_q;
  assign b_minus_a = b_q - a_q;
  assign a_gt_b    = (a_q > b_q);
  assign done_o    = done_q;
  assign g_o       = g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (a_q == b_q)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (a_q == b_q) begin
        g_q <= a_q << k_q;
      end else begin
        case ({a_q[0], b_q[0]})
          2'b00: begin
            a_q <= a_q >> 1;
            b_q <= b_q >> 1;
            k_q <= k_q + 1'b1;
          end
          2'b01: a_q <= a_q >> 1;
          2'b10: b_q <= b_q >> 1;
          default: begin
            if (a_gt_b) begin
              a_q <= a_minus_b >> 1;
            end else begin
              b_q <= b_minus_a >> 1;
            end
          end
        endcase
      end
    end
  end

endmodule

### rtl/rad_div.sv
`timescale 1ns / 1ps

module rad_div #(
  parameter int unsigned MW = 34
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] n_i,
  input  logic [MW-1:0] d_i,
  output logic          done_o,
  output logic [MW-1:0] q_o
);

  // Restoring division, one quotient bit per cycle.
  localparam int unsigned CW = $clog2(MW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [MW-1:0] quo_q, rem_q, d_q;
  logic [MW:0]   rem_sh, rem_diff;
  logic          ge;

  assign rem_sh   = {rem_q, quo_q[MW-1]};
  assign ge       = (rem_sh >= {1'b0, d_q});
  assign rem_diff = rem_sh - {1'b0, d_q};
  assign done_o   = done_q;
  assign q_o      = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= n_i;
      rem_q <= '0;
      d_q   <= d_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[MW-2:0], ge};
      rem_q <= ge ? rem_diff[MW-1:0] : rem_sh[MW-1:0];
    end
  end

endmodule

### rtl/rad_back.sv
`timescale 1ns / 1ps

module rad_back #(
  parameter int unsigned WIDTH = rad_pkg::WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  output logic                              q_pop_o,
  input  rad_pkg::rad_cls_t                 q_cls_i,
  input  logic [6*(WIDTH+1)-1:0]            q_mag_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [rad_pkg::NUM_W-1:0]  res_num_o,
  output logic [rad_pkg::DEN_W-1:0]         res_den_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned MAGW = WIDTH + 1;
  localparam int unsigned MW   = 2 * MAGW;
  localparam int unsigned XW   = (MW > rad_pkg::NUM_W) ? MW : rad_pkg::NUM_W;
  localparam int unsigned YW   = (MW > rad_pkg::DEN_W) ? MW : rad_pkg::DEN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic                       out_valid_q, out_valid_d;
  rad_pkg::rad_cls_t          cls_q;
  logic [MAGW-1:0]            m0a_q, m0b_q, m1a_q, m1b_q, mda_q, mdb_q;
  logic [MW-1:0]              p0_q, p1_q, pd_q;
  logic [MW-1:0]              num_q;
  logic                       neg_q;
  logic                       zero_q;
  logic [MW-1:0]              sum_mag;
  logic                       sum_neg;
  logic                       gcd_start, gcd_done;
  logic [MW-1:0]              gcd_g;
  logic                       div_n_done, div_d_done;
  logic [MW-1:0]              quo_num, quo_den;
  logic                       load_out;
  logic [XW-1:0]              num_ext, num_neg;
  logic [YW-1:0]              den_ext;
  logic [rad_pkg::NUM_W-1:0]  rnum_q;
  logic [rad_pkg::DEN_W-1:0]  rden_q;
  rad_pkg::rad_status_e       rstat_q;

  // Signed-magnitude sum of the two numerator terms.
  always_comb begin
    if (cls_q.s0 == cls_q.s1) begin
      sum_mag = p0_q + p1_q;
      sum_neg = cls_q.s0;
    end else if (p0_q >= p1_q) begin
      sum_mag = p0_q - p1_q;
      sum_neg = cls_q.s0;
    end else begin
      sum_mag = p1_q - p0_q;
      sum_neg = cls_q.s1;
    end
  end

  assign q_pop_o   = (state_q == S_IDLE) && !q_empty_i;
  assign gcd_start = (state_q == S_SUM) && (sum_mag != '0);
  assign load_out  = (state_q == S_OUT) && (!out_valid_q || pop_i);

  rad_gcd #(
    .MW (MW)
  ) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (sum_mag),
    .b_i     (pd_q),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  rad_div #(
    .MW (MW)
  ) u_div_num (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_done),
    .n_i     (num_q),
    .d_i     (gcd_g),
    .done_o  (div_n_done),
    .q_o     (quo_num)
  );

  rad_div #(
    .MW (MW)
  ) u_div_den (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_done),
    .n_i     (pd_q),
    .d_i     (gcd_g),
    .done_o  (div_d_done),
    .q_o     (quo_den)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_cls_i.status != rad_pkg::ST_OK) ? S_OUT : S_MUL;
        end
      end
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = (sum_mag == '0) ? S_OUT : S_GCD;
      S_GCD: begin
        if (gcd_done) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_n_done && div_d_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cls_q  <= q_cls_i;
      zero_q <= (q_cls_i.status != rad_pkg::ST_OK);
      {m0a_q, m0b_q, m1a_q, m1b_q, mda_q, mdb_q} <= q_mag_i;
    end
    if (state_q == S_MUL) begin
      p0_q <= m0a_q * m0b_q;
      p1_q <= m1a_q * m1b_q;
      pd_q <= mda_q * mdb_q;
    end
    if (state_q == S_SUM) begin
      num_q  <= sum_mag;
      neg_q  <= sum_neg ^ cls_q.sd;
      zero_q <= (sum_mag == '0);
    end
  end

  assign num_ext = XW'(quo_num);
  assign num_neg = -num_ext;
  assign den_ext = YW'(quo_den);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rstat_q <= cls_q.status;
      if (zero_q) begin
        rnum_q <= '0;
        rden_q <= rad_pkg::DEN_W'(1);
      end else begin
        rnum_q <= neg_q ? num_neg[rad_pkg::NUM_W-1:0] : num_ext[rad_pkg::NUM_W-1:0];
        rden_q <= den_ext[rad_pkg::DEN_W-1:0];
      end
    end
  end

  assign empty_o   = !out_valid_q;
  assign res_num_o = $signed(rnum_q);
  assign res_den_o = rden_q;
  assign status_o  = rstat_q;

endmodule

### rtl/rational_add_div_reduce.sv
// Rational arithmetic unit with GCD reduction.
// Input channel: an item (opcode, a_num/a_den, b_num/b_den) is taken on a
// rising edge with push_i high and full_o low. Opcode add forms a+b, divide
// forms a/b, and reduce (or the unused code) normalizes a alone.
// Result channel: while empty_o is low the oldest result sits on res_num_o,
// res_den_o and status_o; it is taken on an edge with pop_i high. Every result
// is in lowest terms with a positive denominator. A zero denominator input
// gives 0/1 with status 1, division by a zero fraction gives 0/1 with status 2.
// The binary GCD loop and the two bit-serial dividers, which run side by
// side, set how long an ordinary item takes from acceptance to result; an
// error item goes from the queue straight to the output register, and a
// zero sum skips the GCD and the dividers. Items are worked one at a time,
// so the back takes no new item until the last one's result is loaded.
// The front register and a two-item queue take new items while the
// back works, and a finished result waits in the output register while the
// next item is worked on. A stalled receiver holds the result; the back then
// waits with its next result and the queue fills until full_o rises.
// Reset clears all control state: both channels come up empty and not full.
`timescale 1ns / 1ps
`include "rational_add_div_reduce_macros.svh"

module rational_add_div_reduce #(
  parameter int unsigned WIDTH = rad_pkg::WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [1:0]                        opcode_i,
  input  logic signed [WIDTH-1:0]           a_num_i,
  input  logic signed [WIDTH-1:0]           a_den_i,
  input  logic signed [WIDTH-1:0]           b_num_i,
  input  logic signed [WIDTH-1:0]           b_den_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [rad_pkg::NUM_W-1:0]  res_num_o,
  output logic [rad_pkg::DEN_W-1:0]         res_den_o,
  output logic [1:0]                        status_o
);

  // Each queued item carries its classification and six operand magnitudes.
  localparam int unsigned MAG_BITS = 6 * (WIDTH + 1);
  localparam int unsigned ENTRY_W  = $bits(rad_pkg::rad_cls_t) + MAG_BITS;

  logic                  q_push, q_full, q_pop, q_empty;
  rad_pkg::rad_cls_t     front_cls, back_cls;
  logic [MAG_BITS-1:0]   front_mag, back_mag;
  logic [ENTRY_W-1:0]    q_rdata;
  logic                  err_res, res_zero_one;

  // The front registers the item and works out its status and the operands
  // of the three products.
  rad_front #(
    .WIDTH (WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .opcode_i (opcode_i),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .q_cls_o  (front_cls),
    .q_mag_o  (front_mag)
  );

  rad_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (rad_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({front_cls, front_mag}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign {back_cls, back_mag} = q_rdata;

  // The back multiplies, sums, reduces by the GCD and holds the result.
  rad_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .q_cls_i   (back_cls),
    .q_mag_i   (back_mag),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .status_o  (status_o)
  );

  assign err_res      = !empty_o && (status_o != rad_pkg::ST_OK);
  assign res_zero_one = (res_num_o == '0) && (res_den_o == rad_pkg::DEN_W'(1));

  // An error result is always zero over one.
  `RAD_ASSERT_SAME(a_err_zero_one, clk_i, rst_ni, err_res, res_zero_one, "error result is not 0/1")
  // The back never takes an item from an empty queue.
  `RAD_ASSERT_SAME(a_no_underflow, clk_i, rst_ni, q_pop, !q_empty, "pop from empty queue")
  // An item handed to the queue is waiting there in the next cycle.
  `RAD_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, q_push && !q_full, !q_empty, "queued item was lost")

endmodule

### tb/rational_add_div_reduce_check.sv
`timescale 1ns / 1ps

module rational_add_div_reduce_check #(
  parameter int unsigned WIDTH = rad_pkg::WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic                             full_i,
  input  logic [1:0]                       opcode_i,
  input  logic signed [WIDTH-1:0]          a_num_i,
  input  logic signed [WIDTH-1:0]          a_den_i,
  input  logic signed [WIDTH-1:0]          b_num_i,
  input  logic signed [WIDTH-1:0]          b_den_i,
  input  logic                             empty_i,
  input  logic                             pop_i,
  input  logic signed [rad_pkg::NUM_W-1:0] res_num_i,
  input  logic [rad_pkg::DEN_W-1:0]        res_den_i,
  input  logic [1:0]                       status_i,
  output int                               mismatch_count_o,
  output int                               waiting_o
);
  import rad_pkg::*;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    rad_status_e             status;
  } fraction_t;

  fraction_t expected_fractions[$];
  int        mismatch_total = 0;

  function automatic longint unsigned euclid_gcd(input longint unsigned x,
                                                 input longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Works out the reduced fraction in plain 64-bit signed arithmetic; the
  // products of two WIDTH-bit operands never come near overflow.
  function automatic fraction_t predict_fraction(input logic [1:0] op,
                                                 input logic signed [WIDTH-1:0] an,
                                                 input logic signed [WIDTH-1:0] ad,
                                                 input logic signed [WIDTH-1:0] bn,
                                                 input logic signed [WIDTH-1:0] bd);
    longint          san, sad, sbn, sbd, num, den;
    longint unsigned nmag, dmag, g;
    bit              neg;
    fraction_t       r;
    san = longint'(an);
    sad = longint'(ad);
    sbn = longint'(bn);
    sbd = longint'(bd);
    r.num = '0;
    r.den = DEN_W'(1);
    r.status = ST_OK;
    if (op == OP_ADD || op == OP_DIV) begin
      if (sad == 0 || sbd == 0) begin
        r.status = ST_ZERO_DEN;
        return r;
      end
      if (op == OP_ADD) begin
        num = san * sbd + sbn * sad;
        den = sad * sbd;
      end else begin
        if (sbn == 0) begin
          r.status = ST_DIV_ZERO;
          return r;
        end
        num = san * sbd;
        den = sad * sbn;
      end
    end else begin
      // Reduce, and the spare opcode that behaves like it, use a alone.
      if (sad == 0) begin
        r.status = ST_ZERO_DEN;
        return r;
      end
      num = san;
      den = sad;
    end
    if (num == 0) return r;
    neg  = (num < 0) != (den < 0);
    nmag = (num < 0) ? -num : num;
    dmag = (den < 0) ? -den : den;
    g    = euclid_gcd(nmag, dmag);
    nmag = nmag / g;
    dmag = dmag / g;
    r.num = NUM_W'(neg ? -longint'(nmag) : longint'(nmag));
    r.den = dmag[DEN_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    // Printing stops after 40 mismatches so that a broken design cannot flood the log.
    if (mismatch_total < 40)
      $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fraction_t want;
    if (!rst_ni) begin
      expected_fractions.delete();
      waiting_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      // The result side is checked before the new item is queued, since an
      // item cannot produce its result at the edge that accepts it.
      if (pop_i && !empty_i) begin
        if (expected_fractions.size() == 0) begin
          report_mismatch("result with no item outstanding (numerator)",
                          longint'(res_num_i), 0);
        end else begin
          want = expected_fractions.pop_front();
          if (res_num_i !== want.num)
            report_mismatch("res_num", longint'(res_num_i), longint'(want.num));
          if (res_den_i !== want.den)
            report_mismatch("res_den", longint'(res_den_i), longint'(want.den));
          if (status_i !== want.status)
            report_mismatch("status", longint'(status_i), longint'(want.status));
        end
      end
      if (push_i && !full_i)
        expected_fractions.push_back(predict_fraction(opcode_i, a_num_i, a_den_i,
                                                      b_num_i, b_den_i));
      waiting_o <= expected_fractions.size();
      mismatch_count_o <= mismatch_total;
    end
  end

endmodule

### tb/rational_add_div_reduce_test.sv
`timescale 1ns / 1ps

// Top of the bench for the rational arithmetic unit. This module only makes
// stimulus and gives the verdict; the checker beside the unit watches both
// channels, predicts every result and counts mismatches.
module rational_add_div_reduce_test;
  import rad_pkg::*;

  localparam int unsigned W = WIDTH_DEF;

  // The unused opcode, which the unit treats as reduce.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};

  localparam int RANDOM_ITEMS = 1100;
  // Once this many items have gone in, the receiver stops taking results for
  // a long stretch so that the unit fills up and raises full.
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 1500;
  // Between these item counts neither side idles at all.
  localparam int QUIET_LO = 600;
  localparam int QUIET_HI = 800;
  localparam int IDLE_PCT = 21;
  // This is far beyond the length of any correct run, stalls included.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 150;

  logic                    clk_i;
  logic                    rst_ni   = 1'b0;
  logic                    push_i   = 1'b0;
  logic [1:0]              opcode_i = OP_ADD;
  logic signed [W-1:0]     a_num_i  = '0;
  logic signed [W-1:0]     a_den_i  = '0;
  logic signed [W-1:0]     b_num_i  = '0;
  logic signed [W-1:0]     b_den_i  = '0;
  logic                    pop_i    = 1'b0;
  logic                    full_o;
  logic                    empty_o;
  logic signed [NUM_W-1:0] res_num_o;
  logic [DEN_W-1:0]        res_den_o;
  logic [1:0]              status_o;

  int mismatch_count;
  int results_waiting;
  int items_sent = 0;
  int cycle_count = 0;

  // Tallies for the closing summary.
  int n_add = 0, n_div = 0, n_reduce = 0, n_spare = 0, n_zero_den = 0, n_div_zero = 0;

  rational_add_div_reduce uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .opcode_i  (opcode_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .status_o  (status_o)
  );

  rational_add_div_reduce_check checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_i           (full_o),
    .opcode_i         (opcode_i),
    .a_num_i          (a_num_i),
    .a_den_i          (a_den_i),
    .b_num_i          (b_num_i),
    .b_den_i          (b_den_i),
    .empty_i          (empty_o),
    .pop_i            (pop_i),
    .res_num_i        (res_num_o),
    .res_den_i        (res_den_o),
    .status_i         (status_o),
    .mismatch_count_o (mismatch_count),
    .waiting_o        (results_waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, results_waiting);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Both sides idle at random, except inside the quiet window.
  function automatic int idle_pct();
    return (items_sent >= QUIET_LO && items_sent < QUIET_HI) ? 0 : IDLE_PCT;
  endfunction

  // Receiver. Besides the random idling it makes one long hold-off, counted
  // here in cycles, while the sender keeps pushing items.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        pop_i <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(99) >= idle_pct());
      end
    end
  end

  // Offers one item and returns at the edge that accepts it. Any idle gap
  // comes first, so push is never lowered and raised in the same step.
  task automatic offer_item(input logic [1:0] op,
                            input logic signed [W-1:0] an, input logic signed [W-1:0] ad,
                            input logic signed [W-1:0] bn, input logic signed [W-1:0] bd);
    if ($urandom_range(99) < idle_pct()) begin
      push_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct());
    end
    push_i   <= 1'b1;
    opcode_i <= op;
    a_num_i  <= an;
    a_den_i  <= ad;
    b_num_i  <= bn;
    b_den_i  <= bd;
    do @(posedge clk_i); while (full_o);
    items_sent <= items_sent + 1;
    case (op)
      OP_ADD:  n_add++;
      OP_DIV:  n_div++;
      OP_REDUCE: n_reduce++;
      default: n_spare++;
    endcase
    if (ad == 0 || ((op == OP_ADD || op == OP_DIV) && bd == 0))
      n_zero_den++;
    else if (op == OP_DIV && bn == 0)
      n_div_zero++;
  endtask

  // One operand value in the given style: a multiple of a shared factor so
  // that the reduction has real work, any bit pattern, or an extreme.
  function automatic logic signed [W-1:0] pick_value(input int unsigned style,
                                                     input int unsigned factor,
                                                     input bit nonzero);
    logic signed [W-1:0] v;
    case (style)
      0: v = W'(($signed($urandom_range(400)) - 200) * $signed(factor));
      1: v = W'($urandom);
      default: begin
        case ($urandom_range(6))
          0: v = MIN_VAL;
          1: v = W'(MIN_VAL + 1);
          2: v = -1;
          3: v = 0;
          4: v = 1;
          5: v = MAX_VAL;
          default: v = W'($urandom);
        endcase
      end
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  task automatic random_item();
    logic [1:0]          op;
    logic signed [W-1:0] an, ad, bn, bd;
    int unsigned         kind, style, factor;
    op     = ($urandom_range(99) < 5) ? OP_SPARE : 2'($urandom_range(2));
    kind   = $urandom_range(99);
    factor = $urandom_range(1, 150);
    // Most items are well formed: both denominators nonzero.
    style  = (kind < 35) ? 0 : (kind < 70) ? 1 : 2;
    an = pick_value(style, factor, 1'b0);
    ad = pick_value(style, factor, 1'b1);
    bn = pick_value(style, factor, 1'b0);
    bd = pick_value(style, factor, 1'b1);
    if (kind >= 82 && kind < 92) begin
      // Broken item: one of the denominators is zero.
      if ($urandom_range(1)) ad = '0;
      else bd = '0;
    end else if (kind >= 92) begin
      // A zero numerator; for divide this is usually the divisor.
      if ($urandom_range(3) != 0) bn = '0;
      else an = '0;
    end
    offer_item(op, an, ad, bn, bd);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: plain cases, operand extremes, every opcode and each
    // special case the unit is meant to handle.
    offer_item(OP_ADD, 1, 2, 1, 3);
    offer_item(OP_ADD, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL);
    offer_item(OP_ADD, MAX_VAL, 1, MAX_VAL, 1);
    offer_item(OP_ADD, MIN_VAL, 1, MIN_VAL, 1);
    offer_item(OP_ADD, MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL);
    offer_item(OP_ADD, 1, 2, -1, 2);                // sums to zero
    offer_item(OP_ADD, 7, 3, 5, 1);                 // adding an integer
    offer_item(OP_ADD, 3, 0, 1, 2);                 // zero a denominator
    offer_item(OP_ADD, 3, 4, 1, 0);                 // zero b denominator
    offer_item(OP_DIV, 3, 4, 9, 8);
    offer_item(OP_DIV, 5, 7, 0, 3);                 // zero divisor
    offer_item(OP_DIV, 5, 0, 0, 3);                 // zero denominator wins
    offer_item(OP_DIV, 5, 7, 0, 0);                 // zero denominator wins
    offer_item(OP_DIV, MIN_VAL, MAX_VAL, MAX_VAL, MIN_VAL);
    offer_item(OP_DIV, MIN_VAL, 1, 1, MIN_VAL);
    offer_item(OP_DIV, 0, 5, 3, 7);                 // zero dividend
    offer_item(OP_DIV, -6, -4, 3, -2);
    offer_item(OP_REDUCE, 6, -4, MAX_VAL, 0);       // b is ignored here
    offer_item(OP_REDUCE, MIN_VAL, MIN_VAL, 0, 0);
    offer_item(OP_REDUCE, 0, -5, 1, 1);
    offer_item(OP_REDUCE, 9, 0, 1, 1);
    offer_item(OP_REDUCE, MAX_VAL, MIN_VAL, 1, 1);
    offer_item(OP_SPARE, 12, 18, 1, 0);
    offer_item(OP_SPARE, -1, -1, -1, -1);

    repeat (RANDOM_ITEMS) random_item();
    push_i <= 1'b0;

    // Let every outstanding result come out, then watch for strays.
    do @(posedge clk_i); while (results_waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run sent %0d items: %0d add, %0d divide, %0d reduce, %0d on the spare opcode.",
             n_add + n_div + n_reduce + n_spare, n_add, n_div, n_reduce, n_spare);
    $display("Of these %0d had a zero denominator and %0d divided by zero; %0d mismatches.",
             n_zero_den, n_div_zero, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### rational_add_div_reduce.f
+incdir+rtl
rtl/rad_pkg.sv
rtl/rad_queue.sv
rtl/rad_front.sv
rtl/rad_gcd.sv
rtl/rad_div.sv
rtl/rad_back.sv
rtl/rational_add_div_reduce.sv
tb/rational_add_div_reduce_check.sv
tb/rational_add_div_reduce_test.sv
